/* design/iras_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iras_pkg;

    // item opcodes
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_STATUS  = 1'b1;

    // bus controller status codes, low three bits masked off
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    // bus actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TX    = 2'd2;
    localparam logic [1:0] ACT_NACK  = 2'd3;

    // sequence phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_START     = 3'd1;
    localparam logic [2:0] PH_SLA_W     = 3'd2;
    localparam logic [2:0] PH_REG_ADDR  = 3'd3;
    localparam logic [2:0] PH_DATA_RS   = 3'd4;
    localparam logic [2:0] PH_SLA_R     = 3'd5;
    localparam logic [2:0] PH_RX_NACK   = 3'd6;

    // configuration register indexes
    localparam logic CFG_WR_BUDGET = 1'b0;
    localparam logic CFG_RD_BUDGET = 1'b1;

    // reset values of the retry budgets
    localparam logic [7:0] WR_BUDGET_RESET = 8'h0a;
    localparam logic [7:0] RD_BUDGET_RESET = 8'hff;

    // address byte direction bit
    localparam logic ADDR_BIT_WRITE = 1'b0;
    localparam logic ADDR_BIT_READ  = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic       is_write;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic [7:0] device_address_byte;
        logic [7:0] status_code;
        logic [7:0] received_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] transmit_byte;
        logic       issue_stop;
        logic       finished;
        logic       failed;
        logic [7:0] read_value;
    } t_out_item;

    typedef struct packed {
        logic       write_mode;
        logic [7:0] reg_addr;
        logic [7:0] wr_value;
        logic [7:0] dev_addr;
        logic [2:0] phase;
        logic       data_sent;
        logic [7:0] retries_left;
        logic [7:0] captured_byte;
    } t_seq_state;

endpackage

`default_nettype wire

/* design/iras_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module iras_step (
    input  iras_pkg::t_seq_state i_state,
    input  iras_pkg::t_in_item   i_item,
    input  logic [7:0]           i_wr_budget,
    input  logic [7:0]           i_rd_budget,
    output iras_pkg::t_seq_state o_state,
    output iras_pkg::t_out_item  o_result
);
    import iras_pkg::*;

    logic [7:0] addr_w;
    logic [7:0] addr_r;
    logic [7:0] status;
    logic [7:0] retries_dec;
    logic [1:0] retry_act;
    logic [7:0] retry_tx;

    // address bytes for both directions, bit zero of the saved byte ignored
    assign addr_w      = {i_state.dev_addr[7:1], ADDR_BIT_WRITE};
    assign addr_r      = {i_state.dev_addr[7:1], ADDR_BIT_READ};
    assign status      = i_item.status_code & STATUS_MASK;
    assign retries_dec = i_state.retries_left - 8'd1;

    // action that repeats the current phase
    always_comb begin
        retry_act = ACT_NONE;
        retry_tx  = 8'd0;
        case (i_state.phase)
            PH_START: begin
                retry_act = ACT_START;
            end
            PH_SLA_W: begin
                retry_act = ACT_TX;
                retry_tx  = addr_w;
            end
            PH_REG_ADDR: begin
                retry_act = ACT_TX;
                retry_tx  = i_state.reg_addr;
            end
            PH_DATA_RS: begin
                if (i_state.write_mode) begin
                    retry_act = ACT_TX;
                    retry_tx  = i_state.wr_value;
                end else begin
                    retry_act = ACT_START;
                end
            end
            PH_SLA_R: begin
                retry_act = ACT_TX;
                retry_tx  = addr_r;
            end
            PH_RX_NACK: begin
                retry_act = ACT_NACK;
            end
            default: begin
                retry_act = ACT_NONE;
            end
        endcase
    end

    // next state and result for one item
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.opcode == OP_COMMAND) begin
            o_state.write_mode   = i_item.is_write;
            o_state.reg_addr     = i_item.register_address;
            o_state.wr_value     = i_item.write_value;
            o_state.dev_addr     = i_item.device_address_byte;
            o_state.phase        = PH_START;
            o_state.retries_left = i_item.is_write ? i_wr_budget : i_rd_budget;
            o_result.action      = ACT_START;
        end else begin
            case (status)
                ST_START: begin
                    o_state.phase          = PH_SLA_W;
                    o_result.action        = ACT_TX;
                    o_result.transmit_byte = addr_w;
                end
                ST_MT_SLA_ACK: begin
                    o_state.phase          = PH_REG_ADDR;
                    o_state.data_sent      = 1'b0;
                    o_result.action        = ACT_TX;
                    o_result.transmit_byte = i_state.reg_addr;
                end
                ST_MT_DATA_ACK: begin
                    if (i_state.data_sent) begin
                        o_result.issue_stop = 1'b1;
                        o_result.finished   = 1'b1;
                    end else begin
                        o_state.phase = PH_DATA_RS;
                        if (i_state.write_mode) begin
                            o_state.data_sent      = 1'b1;
                            o_result.action        = ACT_TX;
                            o_result.transmit_byte = i_state.wr_value;
                        end else begin
                            o_result.action = ACT_START;
                        end
                    end
                end
                ST_REP_START: begin
                    o_state.phase          = PH_SLA_R;
                    o_result.action        = ACT_TX;
                    o_result.transmit_byte = addr_r;
                end
                ST_MR_SLA_ACK: begin
                    o_state.phase   = PH_RX_NACK;
                    o_result.action = ACT_NACK;
                end
                ST_MR_DATA_NACK: begin
                    o_state.captured_byte = i_item.received_byte;
                    o_result.issue_stop   = 1'b1;
                    o_result.finished     = 1'b1;
                end
                default: begin
                    // unexpected status: retry the phase or give up; the last retry also gives up
                    if (i_state.retries_left == 8'd0) begin
                        o_result.issue_stop = 1'b1;
                        o_result.finished   = 1'b1;
                        o_result.failed     = 1'b1;
                    end else begin
                        o_state.retries_left   = retries_dec;
                        o_result.action        = retry_act;
                        o_result.transmit_byte = retry_tx;
                        if (retries_dec == 8'd0) begin
                            o_result.issue_stop = 1'b1;
                            o_result.finished   = 1'b1;
                            o_result.failed     = 1'b1;
                        end
                    end
                end
            endcase
        end
        o_result.read_value = o_state.captured_byte;
    end

endmodule

`default_nettype wire

/* design/i2c_register_access_sequencer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Master-side sequencer for single-byte register writes and reads on a
// two-wire bus controller. The input channel (i_in_valid / o_in_ready /
// i_in) carries either a command, which starts a transaction and asks for
// START, or a controller status byte, which yields the next bus action.
// Every input transfer produces exactly one result on the output channel
// (o_out_valid / i_out_ready / o_out): action, byte to send, STOP request,
// finished / failed flags and the last byte read.
// Each input item passes through the input register, then through the decision
// logic into the result register. Throughput is one item per cycle while the
// receiver takes results; the decision logic is combinational and the sequence
// state updates together with the result register. The retry budgets are written
// through i_cfg_wr_en / i_cfg_index / i_cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. Index 0 is
// the write budget, 1 the read. Reset clears the sequence state and both pipeline
// stages and loads the budgets with 10 and 255. When the receiver stalls, the
// result register holds and the input register fills; o_in_ready then drops
// until the result is taken.
module i2c_register_access_sequencer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  iras_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output iras_pkg::t_out_item o_out,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import iras_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_seq_state r_state;
    t_seq_state n_state;
    t_out_item  n_out;
    logic [7:0] r_wr_budget;
    logic [7:0] r_rd_budget;
    logic       advance;
    logic       in_fire;
    logic       step_fire;

    // handshake control
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign step_fire   = r_in_valid && advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // retry budget registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_budget <= WR_BUDGET_RESET;
            r_rd_budget <= RD_BUDGET_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WR_BUDGET: r_wr_budget <= i_cfg_data;
                CFG_RD_BUDGET: r_rd_budget <= i_cfg_data;
                default:       r_wr_budget <= r_wr_budget;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
    end

    // decision logic
    iras_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_wr_budget (r_wr_budget),
        .i_rd_budget (r_rd_budget),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    // a failed transaction always ends with STOP
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.failed |-> r_out.finished && r_out.issue_stop)
        else $error("failure reported without stop");

    // transmit byte is zero unless a byte is sent
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.action != ACT_TX) |-> r_out.transmit_byte == 8'd0)
        else $error("transmit byte set without transmit action");

    // an empty result register never blocks the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // retry count only grows when a command is processed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(step_fire && (r_in.opcode == OP_COMMAND))
        |-> r_state.retries_left <= $past(r_state.retries_left))
        else $error("retry count grew without a command");

    // a processed command enters the start phase
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire && (r_in.opcode == OP_COMMAND)
        |=> r_state.phase == PH_START && r_out.action == ACT_START)
        else $error("command did not start a transaction");

endmodule

`default_nettype wire

/* tb/iras_sequence_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module iras_sequence_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  iras_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  iras_pkg::t_out_item i_out,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output int                  o_pending,
    output int                  o_mismatches,
    output int                  o_checked,
    output int                  o_exhausted
);

    import iras_pkg::*;

    // shadow of the retry budget registers
    logic [7:0] wr_budget;
    logic [7:0] rd_budget;

    // shadow of the transaction being sequenced
    logic       txn_is_write;
    logic [7:0] txn_reg;
    logic [7:0] txn_data;
    logic [7:0] txn_dev;
    logic [2:0] step;
    logic       data_loaded;
    logic [7:0] retries;
    logic [7:0] last_rx;

    // bus actions still owed by the block, oldest first
    t_out_item expected_actions[$];
    t_out_item want;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        o_checked    = 0;
        o_exhausted  = 0;
    end

    // next bus action for one input transfer, advancing the shadow state
    function automatic t_out_item next_bus_action(input t_in_item item);
        t_out_item  res;
        logic [7:0] addr_wr;
        logic [7:0] addr_rd;
        logic [7:0] masked;
        addr_wr = {txn_dev[7:1], ADDR_BIT_WRITE};
        addr_rd = {txn_dev[7:1], ADDR_BIT_READ};
        res     = '0;
        if (item.opcode == OP_COMMAND) begin
            txn_is_write = item.is_write;
            txn_reg      = item.register_address;
            txn_data     = item.write_value;
            txn_dev      = item.device_address_byte;
            step         = PH_START;
            retries      = item.is_write ? wr_budget : rd_budget;
            res.action   = ACT_START;
        end else begin
            masked = item.status_code & STATUS_MASK;
            case (masked)
                ST_START: begin
                    step              = PH_SLA_W;
                    res.action        = ACT_TX;
                    res.transmit_byte = addr_wr;
                end
                ST_MT_SLA_ACK: begin
                    step              = PH_REG_ADDR;
                    data_loaded       = 1'b0;
                    res.action        = ACT_TX;
                    res.transmit_byte = txn_reg;
                end
                ST_MT_DATA_ACK: begin
                    if (data_loaded) begin
                        res.issue_stop = 1'b1;
                        res.finished   = 1'b1;
                    end else begin
                        step = PH_DATA_RS;
                        if (txn_is_write) begin
                            data_loaded       = 1'b1;
                            res.action        = ACT_TX;
                            res.transmit_byte = txn_data;
                        end else begin
                            res.action = ACT_START;
                        end
                    end
                end
                ST_REP_START: begin
                    step              = PH_SLA_R;
                    res.action        = ACT_TX;
                    res.transmit_byte = addr_rd;
                end
                ST_MR_SLA_ACK: begin
                    step       = PH_RX_NACK;
                    res.action = ACT_NACK;
                end
                ST_MR_DATA_NACK: begin
                    last_rx        = item.received_byte;
                    res.issue_stop = 1'b1;
                    res.finished   = 1'b1;
                end
                default: begin
                    // unexpected status: repeat the step, or give up when the budget is gone
                    if (retries == 8'd0) begin
                        res.issue_stop = 1'b1;
                        res.finished   = 1'b1;
                        res.failed     = 1'b1;
                    end else begin
                        retries = retries - 8'd1;
                        case (step)
                            PH_START: res.action = ACT_START;
                            PH_SLA_W: begin
                                res.action        = ACT_TX;
                                res.transmit_byte = addr_wr;
                            end
                            PH_REG_ADDR: begin
                                res.action        = ACT_TX;
                                res.transmit_byte = txn_reg;
                            end
                            PH_DATA_RS: begin
                                if (txn_is_write) begin
                                    res.action        = ACT_TX;
                                    res.transmit_byte = txn_data;
                                end else begin
                                    res.action = ACT_START;
                                end
                            end
                            PH_SLA_R: begin
                                res.action        = ACT_TX;
                                res.transmit_byte = addr_rd;
                            end
                            PH_RX_NACK: res.action = ACT_NACK;
                            default: res.action = ACT_NONE;
                        endcase
                        if (retries == 8'd0) begin
                            res.issue_stop = 1'b1;
                            res.finished   = 1'b1;
                            res.failed     = 1'b1;
                        end
                    end
                end
            endcase
        end
        res.read_value = last_rx;
        return res;
    endfunction

    // watch the register port and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_budget    = WR_BUDGET_RESET;
            rd_budget    = RD_BUDGET_RESET;
            txn_is_write = 1'b0;
            txn_reg      = '0;
            txn_data     = '0;
            txn_dev      = '0;
            step         = PH_IDLE;
            data_loaded  = 1'b0;
            retries      = '0;
            last_rx      = '0;
            expected_actions.delete();
            o_pending    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_WR_BUDGET) begin
                    wr_budget = i_cfg_data;
                end else begin
                    rd_budget = i_cfg_data;
                end
            end

            // result transfer against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (i_out.failed === 1'b1) begin
                    o_exhausted++;
                end
                if (expected_actions.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("%0t: result act=%0d tx=%02h stop=%0b fin=%0b fail=%0b rd=%02h with nothing expected",
                                 $time, i_out.action, i_out.transmit_byte, i_out.issue_stop,
                                 i_out.finished, i_out.failed, i_out.read_value);
                    end
                end else begin
                    want = expected_actions.pop_front();
                    o_checked++;
                    if (i_out.action !== want.action ||
                        i_out.transmit_byte !== want.transmit_byte ||
                        i_out.issue_stop !== want.issue_stop ||
                        i_out.finished !== want.finished ||
                        i_out.failed !== want.failed ||
                        i_out.read_value !== want.read_value) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: expected act=%0d tx=%02h stop=%0b fin=%0b fail=%0b rd=%02h",
                                     $time, want.action, want.transmit_byte, want.issue_stop,
                                     want.finished, want.failed, want.read_value);
                            $display("%0t:      got act=%0d tx=%02h stop=%0b fin=%0b fail=%0b rd=%02h",
                                     $time, i_out.action, i_out.transmit_byte, i_out.issue_stop,
                                     i_out.finished, i_out.failed, i_out.read_value);
                        end
                    end
                end
            end

            // input transfer: predict its bus action
            if (i_in_valid && i_in_ready) begin
                expected_actions.push_back(next_bus_action(i_in));
            end
            o_pending = expected_actions.size();
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    import iras_pkg::*;

    // status codes the sequence never expects
    localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_BUS_ERROR    = 8'h00;
    localparam logic [7:0] ST_NO_INFO      = 8'hF8;

    localparam int LONG_HOLD       = 200;
    localparam int PHASE_ITEMS     = 280;
    localparam int DIRECTED_ITEMS  = 22;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_index = CFG_WR_BUDGET;
    logic [7:0] cfg_data = '0;

    int pending;
    int mismatches;
    int checked;
    int exhausted;

    int items_sent    = 0;
    int write_txns    = 0;
    int read_txns     = 0;
    bit tx_gaps_on    = 1'b1;
    bit rx_gaps_on    = 1'b1;
    bit long_hold_req = 1'b0;

    i2c_register_access_sequencer_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    iras_sequence_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_exhausted  (exhausted)
    );

    // clock
    initial begin
        forever #2 clk = ~clk;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("** i2c_register_access_sequencer_unit: FAILED **");
        $finish;
    end

    // idle gap length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int hold;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = rx_gaps_on ? pick_gap() : 0;
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // command item with random event fields
    function automatic t_in_item make_command(input logic wr, input logic [7:0] reg_a,
                                              input logic [7:0] val, input logic [7:0] dev);
        t_in_item it;
        it.opcode              = OP_COMMAND;
        it.is_write            = wr;
        it.register_address    = reg_a;
        it.write_value         = val;
        it.device_address_byte = dev;
        it.status_code         = 8'($urandom);
        it.received_byte       = 8'($urandom);
        return it;
    endfunction

    // status event item with random command fields
    function automatic t_in_item make_status(input logic [7:0] code, input logic [7:0] rx);
        t_in_item it;
        it.opcode              = OP_STATUS;
        it.is_write            = 1'($urandom);
        it.register_address    = 8'($urandom);
        it.write_value         = 8'($urandom);
        it.device_address_byte = 8'($urandom);
        it.status_code         = code;
        it.received_byte       = rx;
        return it;
    endfunction

    // status code with random don't-care low bits
    function automatic logic [7:0] with_low(input logic [7:0] code);
        return {code[7:3], 3'($urandom_range(0, 7))};
    endfunction

    // a status the current step does not expect, sometimes any code at all
    function automatic logic [7:0] noise_status();
        case ($urandom_range(0, 7))
            0: return ST_MT_SLA_NACK;
            1: return ST_MT_DATA_NACK;
            2: return ST_ARB_LOST;
            3: return ST_MR_SLA_NACK;
            4: return ST_MR_DATA_ACK;
            5: return ST_BUS_ERROR;
            6: return ST_NO_INFO;
            default: return 8'($urandom);
        endcase
    endfunction

    // one input transfer, preceded by an optional idle gap
    task automatic send_item(input t_in_item item);
        int gap;
        bit accepted;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge clk);
            accepted = in_ready;
            @(posedge clk);
        end
        items_sent++;
    endtask

    // stop offering and wait for every owed result
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // both retry budgets, written back to back while idle
    task automatic set_budgets(input logic [7:0] wr, input logic [7:0] rd);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WR_BUDGET;
        cfg_data  <= wr;
        @(posedge clk);
        cfg_index <= CFG_RD_BUDGET;
        cfg_data  <= rd;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // well-formed write or read sequence with random content and injected noise
    task automatic run_transaction();
        logic       wr;
        logic [7:0] codes [6];
        int         n;
        int         k;
        wr = 1'($urandom);
        send_item(make_command(wr, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 254))));
        codes[0] = ST_START;
        codes[1] = ST_MT_SLA_ACK;
        codes[2] = ST_MT_DATA_ACK;
        if (wr) begin
            codes[3] = ST_MT_DATA_ACK;
            n = 4;
            write_txns++;
        end else begin
            codes[3] = ST_REP_START;
            codes[4] = ST_MR_SLA_ACK;
            codes[5] = ST_MR_DATA_NACK;
            n = 6;
            read_txns++;
        end
        for (k = 0; k < n; k++) begin
            // abandoned midway, the next command restarts the block
            if ($urandom_range(0, 99) < 4) return;
            while ($urandom_range(0, 99) < 12) begin
                send_item(make_status(noise_status(), 8'($urandom)));
            end
            send_item(make_status(with_low(codes[k]), 8'($urandom)));
        end
    endtask

    // stimulus and verdict
    initial begin
        int         phase_idx;
        int         target;
        logic [7:0] wr_b;
        logic [7:0] rd_b;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset budgets, empty budget while idle
        send_item(make_status(ST_BUS_ERROR, 8'hA5));
        // write with all-ones register and data fields, device address byte 8'hFE
        send_item(make_command(1'b1, 8'hFF, 8'hFF, 8'hFE));
        send_item(make_status(ST_START | 8'h07, 8'hFF));
        send_item(make_status(ST_MT_SLA_ACK, 8'h00));
        send_item(make_status(ST_MT_DATA_ACK, 8'h00));
        send_item(make_status(ST_MT_DATA_ACK, 8'hFF));
        // read with zero fields and odd device address, one retry
        send_item(make_command(1'b0, 8'h00, 8'h00, 8'h01));
        send_item(make_status(ST_START, 8'h00));
        send_item(make_status(ST_MT_SLA_NACK, 8'h00));
        send_item(make_status(ST_MT_SLA_ACK | 8'h07, 8'hFF));
        send_item(make_status(ST_MT_DATA_ACK | 8'h05, 8'h00));
        send_item(make_status(ST_REP_START | 8'h02, 8'hFF));
        send_item(make_status(ST_MR_SLA_ACK | 8'h07, 8'h00));
        send_item(make_status(ST_MR_DATA_NACK | 8'h06, 8'h00));
        // data status after the end: captured again, out of order
        send_item(make_status(ST_MR_DATA_NACK, 8'hFF));
        // command while busy, then codes out of order
        send_item(make_command(1'b1, 8'h5A, 8'hA5, 8'h80));
        send_item(make_status(ST_START, 8'h3C));
        send_item(make_command(1'b0, 8'hC3, 8'h3C, 8'h7E));
        send_item(make_status(ST_REP_START, 8'h11));
        send_item(make_status(ST_MR_SLA_ACK, 8'h22));
        send_item(make_status(8'hFF, 8'h33));
        send_item(make_status(ST_MT_DATA_ACK, 8'h44));
        settle();

        // random phases, each with its own budget setting
        for (phase_idx = 0; phase_idx < 6; phase_idx++) begin
            case (phase_idx)
                0: begin wr_b = 8'd1;   rd_b = 8'd1;   end
                1: begin wr_b = 8'd255; rd_b = 8'd255; end
                2: begin wr_b = 8'd3;   rd_b = 8'd2;   end
                3: begin wr_b = 8'd0;   rd_b = 8'd0;   end
                4: begin
                    wr_b = 8'($urandom_range(1, 255));
                    rd_b = 8'($urandom_range(1, 255));
                end
                default: begin wr_b = WR_BUDGET_RESET; rd_b = RD_BUDGET_RESET; end
            endcase
            set_budgets(wr_b, rd_b);
            if (phase_idx == 2) begin
                // receiver holds off while items keep coming back to back
                tx_gaps_on    = 1'b0;
                long_hold_req = 1'b1;
            end
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_item(make_status(8'($urandom), 8'($urandom)));
                end else begin
                    run_transaction();
                end
                if ($urandom_range(0, 99) < 10) tx_gaps_on = !tx_gaps_on;
                if ($urandom_range(0, 99) < 10) rx_gaps_on = !rx_gaps_on;
                if ($urandom_range(0, 99) < 3) settle();
            end
            settle();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        $display("covered %0d items (%0d directed), %0d write and %0d read sequences, 7 budget settings",
                 items_sent, DIRECTED_ITEMS, write_txns, read_txns);
        $display("%0d results compared, %0d of them ended on an exhausted retry budget",
                 checked, exhausted);
        if (mismatches == 0 && pending == 0) begin
            $display("** i2c_register_access_sequencer_unit: PASSED **");
        end else begin
            $display("** i2c_register_access_sequencer_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
